[hw/rtl/euler_pkg.sv]
// Shared constants and the arctangent table for the Euler-angle rotation matrix pipeline.
package euler_pkg;

    localparam int CORDIC_STEPS    = 30;
    localparam int WORK_FRAC       = 30;
    localparam int TURN_BITS       = 32;
    localparam int XY_W            = 34;
    localparam int ZW              = 34;
    localparam int CORDIC_GAIN_INV = 652032874;

    typedef logic signed [XY_W-1:0] cordic_xy_t;
    typedef logic signed [ZW-1:0]   cordic_z_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic cordic_z_t atan_turn(input int idx);
        cordic_z_t val;
        case (idx)
            0:       val = ZW'(536870912);
            1:       val = ZW'(316933406);
            2:       val = ZW'(167458907);
            3:       val = ZW'(85004756);
            4:       val = ZW'(42667331);
            5:       val = ZW'(21354465);
            6:       val = ZW'(10679838);
            7:       val = ZW'(5340245);
            8:       val = ZW'(2670163);
            9:       val = ZW'(1335087);
            10:      val = ZW'(667544);
            11:      val = ZW'(333772);
            12:      val = ZW'(166886);
            13:      val = ZW'(83443);
            14:      val = ZW'(41722);
            15:      val = ZW'(20861);
            16:      val = ZW'(10430);
            17:      val = ZW'(5215);
            18:      val = ZW'(2608);
            19:      val = ZW'(1304);
            20:      val = ZW'(652);
            21:      val = ZW'(326);
            22:      val = ZW'(163);
            23:      val = ZW'(81);
            24:      val = ZW'(41);
            25:      val = ZW'(20);
            26:      val = ZW'(10);
            27:      val = ZW'(5);
            28:      val = ZW'(3);
            29:      val = ZW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/euler_xyz_to_rotation_matrix.sv]
// Euler XYZ angles to 3x3 rotation matrix: pipelined CORDIC, products and saturation.
//
// Input channel (s_*): one transaction carries angle_x, angle_y, angle_z, signed binary
// angles where 2^ANGLE_BITS is a full turn. Output channel (m_*): one transaction carries
// the nine matrix entries m00..m22, row-major, signed Q2.FRAC_BITS clamped to +-1.0.
// Every input transaction yields exactly one output transaction, in order.
//
// Throughput: one transaction per cycle while no output stall holds the pipeline. On its way
// to m_tvalid a transaction passes the angle prep register, 30 CORDIC iteration stages, a
// round/clamp stage, three multiply/round stages and the output register.
//
// A stall on m_tready fills a one-entry skid register behind the output register; only
// then does the whole pipeline freeze and s_tready drop, so s_tready never depends
// combinationally on m_tready. Nothing is dropped or duplicated across a stall.
//
// Reset clears all valid bits and the output/skid flags; data registers are not reset.
// The block comes out of reset empty and ready.
module euler_xyz_to_rotation_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14,
    localparam int OUT_BITS  = FRAC_BITS + 2,
    localparam int IN_W      = ((3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((9 * OUT_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // angle_x, angle_y, angle_z
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);
    import euler_pkg::*;

    localparam int W        = OUT_BITS;
    localparam int PW       = 2 * W;
    localparam int AW       = 2 * W + 1;
    localparam int RSH      = WORK_FRAC - FRAC_BITS;
    localparam int ANG_PAD  = TURN_BITS - ANGLE_BITS;

    typedef logic signed [W-1:0]  trig_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [AW-1:0] acc_t;

    localparam trig_t ONE_W = trig_t'(1) <<< FRAC_BITS;

    function automatic trig_t round_clamp(input acc_t v);
        acc_t r;
        acc_t one;
        trig_t res;
        one = acc_t'(1) <<< FRAC_BITS;
        r   = (v + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > one)
            res = ONE_W;
        else if (r < -one)
            res = -ONE_W;
        else
            res = r[W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- flow control
    logic ce;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic [OUT_W-1:0] final_data;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------- valid pipeline
    logic [CORDIC_STEPS:0] cv_reg;
    logic rnd_valid_reg;
    logic p1_valid_reg;
    logic p2_valid_reg;
    logic p3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg        <= '0;
            rnd_valid_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
        end
        else if (ce)
        begin
            cv_reg        <= {cv_reg[CORDIC_STEPS-1:0], s_tvalid};
            rnd_valid_reg <= cv_reg[CORDIC_STEPS];
            p1_valid_reg  <= rnd_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
        end
    end

    // ---------------------------------------------------------------- CORDIC
    cordic_xy_t x_reg [0:CORDIC_STEPS][0:2];
    cordic_xy_t y_reg [0:CORDIC_STEPS][0:2];
    cordic_z_t  z_reg [0:CORDIC_STEPS][0:2];
    logic [2:0] flip_reg [0:CORDIC_STEPS];

    logic [ANGLE_BITS-1:0] angle_in [0:2];
    assign angle_in[0] = s_tdata[ANGLE_BITS-1:0];
    assign angle_in[1] = s_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
    assign angle_in[2] = s_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS];

    // Fold quadrants 1 and 2 by a half turn; the result is negated at the end.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic [TURN_BITS-1:0] u;
                u = {angle_in[a], {ANG_PAD{1'b0}}};
                flip_reg[0][a] <= u[TURN_BITS-1] ^ u[TURN_BITS-2];
                z_reg[0][a]    <= ZW'(signed'({u[TURN_BITS-2], u[TURN_BITS-2:0]}));
                x_reg[0][a]    <= XY_W'(CORDIC_GAIN_INV);
                y_reg[0][a]    <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                flip_reg[k+1] <= flip_reg[k];
                for (int a = 0; a < 3; a++)
                begin
                    if (!z_reg[k][a][ZW-1])
                    begin
                        x_reg[k+1][a] <= x_reg[k][a] - (y_reg[k][a] >>> k);
                        y_reg[k+1][a] <= y_reg[k][a] + (x_reg[k][a] >>> k);
                        z_reg[k+1][a] <= z_reg[k][a] - atan_turn(k);
                    end
                    else
                    begin
                        x_reg[k+1][a] <= x_reg[k][a] + (y_reg[k][a] >>> k);
                        y_reg[k+1][a] <= y_reg[k][a] - (x_reg[k][a] >>> k);
                        z_reg[k+1][a] <= z_reg[k][a] + atan_turn(k);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- round and clamp
    trig_t sn_reg [0:2];
    trig_t cs_reg [0:2];
    trig_t sn_next [0:2];
    trig_t cs_next [0:2];

    always_comb
    begin
        cordic_xy_t xv;
        cordic_xy_t yv;
        cordic_xy_t xr;
        cordic_xy_t yr;
        cordic_xy_t one_xy;
        one_xy = cordic_xy_t'(1) <<< FRAC_BITS;
        for (int a = 0; a < 3; a++)
        begin
            xv = flip_reg[CORDIC_STEPS][a] ? -x_reg[CORDIC_STEPS][a] : x_reg[CORDIC_STEPS][a];
            yv = flip_reg[CORDIC_STEPS][a] ? -y_reg[CORDIC_STEPS][a] : y_reg[CORDIC_STEPS][a];
            xr = (xv + (cordic_xy_t'(1) <<< (RSH - 1))) >>> RSH;
            yr = (yv + (cordic_xy_t'(1) <<< (RSH - 1))) >>> RSH;
            if (xr > one_xy)
                cs_next[a] = ONE_W;
            else if (xr < -one_xy)
                cs_next[a] = -ONE_W;
            else
                cs_next[a] = xr[W-1:0];
            if (yr > one_xy)
                sn_next[a] = ONE_W;
            else if (yr < -one_xy)
                sn_next[a] = -ONE_W;
            else
                sn_next[a] = yr[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sn_reg <= sn_next;
            cs_reg <= cs_next;
        end
    end

    // ---------------------------------------------------------------- stage P1: products
    prod_t cycz_reg, cysz_reg, sxcy_reg, cxcy_reg, sxsy_reg, cxsy_reg;
    prod_t cxsz1_reg, cxcz1_reg, sxsz1_reg, sxcz1_reg;
    trig_t nsy1_reg, cz1_reg, sz1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cycz_reg  <= cs_reg[1] * cs_reg[2];
            cysz_reg  <= cs_reg[1] * sn_reg[2];
            sxcy_reg  <= sn_reg[0] * cs_reg[1];
            cxcy_reg  <= cs_reg[0] * cs_reg[1];
            sxsy_reg  <= sn_reg[0] * sn_reg[1];
            cxsy_reg  <= cs_reg[0] * sn_reg[1];
            cxsz1_reg <= cs_reg[0] * sn_reg[2];
            cxcz1_reg <= cs_reg[0] * cs_reg[2];
            sxsz1_reg <= sn_reg[0] * sn_reg[2];
            sxcz1_reg <= sn_reg[0] * cs_reg[2];
            nsy1_reg  <= -sn_reg[1];
            cz1_reg   <= cs_reg[2];
            sz1_reg   <= sn_reg[2];
        end
    end

    // ---------------------------------------------------------------- stage P2: round pairs
    trig_t e00_2_reg, e01_2_reg, e02_2_reg, e12_2_reg, e22_2_reg;
    trig_t t1_reg, t2_reg, cz2_reg, sz2_reg;
    prod_t cxsz2_reg, cxcz2_reg, sxsz2_reg, sxcz2_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            e00_2_reg <= round_clamp(AW'(cycz_reg));
            e01_2_reg <= round_clamp(AW'(cysz_reg));
            e02_2_reg <= nsy1_reg;
            e12_2_reg <= round_clamp(AW'(sxcy_reg));
            e22_2_reg <= round_clamp(AW'(cxcy_reg));
            t1_reg    <= round_clamp(AW'(sxsy_reg));
            t2_reg    <= round_clamp(AW'(cxsy_reg));
            cz2_reg   <= cz1_reg;
            sz2_reg   <= sz1_reg;
            cxsz2_reg <= cxsz1_reg;
            cxcz2_reg <= cxcz1_reg;
            sxsz2_reg <= sxsz1_reg;
            sxcz2_reg <= sxcz1_reg;
        end
    end

    // ---------------------------------------------------------------- stage P3: third factor
    trig_t e00_3_reg, e01_3_reg, e02_3_reg, e12_3_reg, e22_3_reg;
    prod_t t1cz_reg, t1sz_reg, t2cz_reg, t2sz_reg;
    prod_t cxsz3_reg, cxcz3_reg, sxsz3_reg, sxcz3_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            e00_3_reg <= e00_2_reg;
            e01_3_reg <= e01_2_reg;
            e02_3_reg <= e02_2_reg;
            e12_3_reg <= e12_2_reg;
            e22_3_reg <= e22_2_reg;
            t1cz_reg  <= t1_reg * cz2_reg;
            t1sz_reg  <= t1_reg * sz2_reg;
            t2cz_reg  <= t2_reg * cz2_reg;
            t2sz_reg  <= t2_reg * sz2_reg;
            cxsz3_reg <= cxsz2_reg;
            cxcz3_reg <= cxcz2_reg;
            sxsz3_reg <= sxsz2_reg;
            sxcz3_reg <= sxcz2_reg;
        end
    end

    // ---------------------------------------------------------------- final sums
    trig_t m10, m11, m20, m21;

    always_comb
    begin
        m10 = round_clamp(AW'(t1cz_reg) - AW'(cxsz3_reg));
        m11 = round_clamp(AW'(t1sz_reg) + AW'(cxcz3_reg));
        m20 = round_clamp(AW'(t2cz_reg) + AW'(sxsz3_reg));
        m21 = round_clamp(AW'(t2sz_reg) - AW'(sxcz3_reg));
        // zero-filled up to whole bytes
        final_data = OUT_W'({e22_3_reg, m21, m20, e12_3_reg, m11, m10,
                             e02_3_reg, e01_3_reg, e00_3_reg});
    end

    // ---------------------------------------------------------------- output and skid
    logic incoming;
    logic out_fire;

    assign incoming = ce && p3_valid_reg;
    assign out_fire = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (incoming)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (incoming)
        begin
            if (out_valid_reg && !out_fire)
                skid_data_reg <= final_data;
            else
                out_data_reg <= final_data;
        end
    end

endmodule

[bench/rotation_matrix_checker.sv]
// Watches both channels of the rotation-matrix block, predicts each matrix and compares it.
module rotation_matrix_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,   // angle_x, angle_y, angle_z
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output int           fail_count,
    output int           pending
);

    localparam int     FRAC       = 14;
    localparam int     STEPS      = 30;
    localparam longint UNIT       = 64'sd1 <<< FRAC;
    localparam longint GAIN_RECIP = 64'sd652032874;
    localparam int     PRINT_CAP  = 40;

    typedef logic signed [15:0] entry_t;
    typedef entry_t [8:0] rotation_t;   // entry 0 (m00) in the low bits

    // arctan(2^-i), in 2^-32 of a turn
    longint arctan_turn [0:STEPS-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1
    };

    string entry_name [0:8] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

    rotation_t rotation_q [$];

    function automatic longint round_at(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint saturate_unit(input longint v);
        if (v > UNIT)
            return UNIT;
        if (v < -UNIT)
            return -UNIT;
        return v;
    endfunction

    // CORDIC in rotation mode on [-90, +90) degrees; other half-plane is folded by 180
    function automatic void angle_sin_cos(input logic [15:0] ang, output longint s_val,
                                          output longint c_val);
        logic [31:0] turn;
        bit          fold;
        longint      x, y, z, nx, dx, dy;
        turn = {ang, 16'h0000};
        fold = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
        if (fold)
            turn = turn + 32'h8000_0000;
        z = longint'($signed(turn));
        x = GAIN_RECIP;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                nx = x - dx;
                y  = y + dy;
                z  = z - arctan_turn[i];
            end
            else
            begin
                nx = x + dx;
                y  = y - dy;
                z  = z + arctan_turn[i];
            end
            x = nx;
        end
        if (fold)
        begin
            x = -x;
            y = -y;
        end
        c_val = saturate_unit(round_at(x, 30 - FRAC));
        s_val = saturate_unit(round_at(y, 30 - FRAC));
    endfunction

    function automatic longint prod2(input longint a, input longint b);
        return saturate_unit(round_at(a * b, FRAC));
    endfunction

    // (a*b) rounded, times c, plus or minus d*e, rounded once
    function automatic longint prod3_sum(input longint a, input longint b, input longint c,
                                         input longint d, input longint e, input bit negate);
        longint lead, acc;
        lead = saturate_unit(round_at(a * b, FRAC));
        acc  = negate ? lead * c - d * e : lead * c + d * e;
        return saturate_unit(round_at(acc, FRAC));
    endfunction

    function automatic rotation_t predict_rotation(input logic [47:0] angles);
        longint    sx, cx, sy, cy, sz, cz;
        rotation_t r;
        angle_sin_cos(angles[15:0], sx, cx);
        angle_sin_cos(angles[31:16], sy, cy);
        angle_sin_cos(angles[47:32], sz, cz);
        r[0] = entry_t'(prod2(cy, cz));
        r[1] = entry_t'(prod2(cy, sz));
        r[2] = entry_t'(saturate_unit(-sy));
        r[3] = entry_t'(prod3_sum(sx, sy, cz, cx, sz, 1'b1));
        r[4] = entry_t'(prod3_sum(sx, sy, sz, cx, cz, 1'b0));
        r[5] = entry_t'(prod2(sx, cy));
        r[6] = entry_t'(prod3_sum(cx, sy, cz, sx, sz, 1'b0));
        r[7] = entry_t'(prod3_sum(cx, sy, sz, sx, cz, 1'b1));
        r[8] = entry_t'(prod2(cx, cy));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        rotation_t want, got;
        string     diffs;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                rotation_q.push_back(predict_rotation(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (rotation_q.size() == 0)
                    report_mismatch($sformatf("unexpected output transaction %h", m_tdata));
                else
                begin
                    want  = rotation_q.pop_front();
                    diffs = "";
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== want[i])
                            diffs = {diffs, $sformatf(" %s got %0d want %0d",
                                                      entry_name[i], got[i], want[i])};
                    if (diffs != "")
                        report_mismatch(diffs);
                end
            end
            pending = rotation_q.size();
        end
    end

endmodule

[bench/tb_euler_xyz_to_rotation_matrix.sv]
// Stimulus, flow control and verdict for the Euler-angle rotation matrix block.
module tb_euler_xyz_to_rotation_matrix;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 50;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [143:0] m_tdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    bit hold_go     = 1'b0;
    bit hold_off    = 1'b0;

    euler_xyz_to_rotation_matrix u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rotation_matrix_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // long receiver hold-off so the pipeline and skid fill and s_tready drops
    initial
    begin
        @(posedge clk);
        while (!hold_go)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // biased toward quadrant edges, where the 180-degree fold and clamping matter
    function automatic logic [15:0] pick_angle();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            6, 7:    return 16'($urandom_range(3) * 16384 + $urandom_range(8) - 4);
            8:       return 16'($urandom_range(1) ? 16'h8000 : 16'h7FFF);
            9:       return 16'($urandom_range(128) - 64);
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic random_run(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct <= stall;
        repeat (count)
            send_angles(pick_angle(), pick_angle(), pick_angle());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, quadrant edges, extremes, gimbal lock
        send_angles(16'h0000, 16'h0000, 16'h0000);
        send_angles(16'h4000, 16'h0000, 16'h0000);
        send_angles(16'h0000, 16'h4000, 16'h0000);
        send_angles(16'h0000, 16'h0000, 16'h4000);
        send_angles(16'h8000, 16'h8000, 16'h8000);
        send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_angles(16'hC000, 16'hC000, 16'hC000);
        send_angles(16'h3FFF, 16'hBFFF, 16'h4001);
        send_angles(16'hC001, 16'h2000, 16'hE000);
        send_angles(16'h2000, 16'h2000, 16'h2000);
        send_angles(16'h1234, 16'h4000, 16'h5678);
        send_angles(16'h1234, 16'hC000, 16'h5678);
        send_angles(16'h1000, 16'h3000, 16'hB000);
        send_angles(16'h5555, 16'hAAAA, 16'h5555);
        send_angles(16'h0001, 16'hFFFF, 16'h0001);
        send_angles(16'hFFFF, 16'h0000, 16'h7FFF);
        send_angles(16'h8001, 16'h7FFE, 16'hBFFF);
        send_angles(16'h4001, 16'hC001, 16'h3FFF);
        send_angles(16'h6000, 16'hA000, 16'h2AAA);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);

        random_run(400, 0, 0);
        random_run(350, 48, 0);
        random_run(350, 0, 48);
        random_run(350, 23, 23);

        idle_pct  = 0;
        stall_pct <= 0;
        hold_go   <= 1'b1;
        repeat (200)
            send_angles(pick_angle(), pick_angle(), pick_angle());

        random_run(200, 23, 23);
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[euler_xyz_to_rotation_matrix.f]
hw/rtl/euler_pkg.sv
hw/rtl/euler_xyz_to_rotation_matrix.sv
bench/rotation_matrix_checker.sv
bench/tb_euler_xyz_to_rotation_matrix.sv
